// ----- sv/fet_pkg.sv -----
// ============================================================================
// fet_pkg: shared types and constants of the filter expression tokenizer
// Token kinds, error codes, lexer modes and the token record layout.
// ============================================================================
package fet_pkg;

  localparam int unsigned REC_W = 5 + 16 + 16 + 16 + 64 + 1 + 2;

  typedef enum logic [4:0] {
    K_END = 5'd0, K_IDENT = 5'd1, K_STRING = 5'd2, K_INT = 5'd3, K_FLOAT = 5'd4,
    K_BOOL = 5'd5, K_NULL = 5'd6, K_EQ = 5'd7, K_NE = 5'd8, K_GT = 5'd9,
    K_GE = 5'd10, K_LT = 5'd11, K_LE = 5'd12, K_AND = 5'd13, K_OR = 5'd14,
    K_NOT = 5'd15, K_LPAREN = 5'd16, K_RPAREN = 5'd17, K_COMMA = 5'd18,
    K_COLON = 5'd19, K_ERROR = 5'd20
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE = 2'd0, E_UNTERM = 2'd1, E_UNEXP = 2'd2, E_OVFL = 2'd3
  } err_t;

  // lexer modes, one-hot
  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_MINUS   = 10'b0000000010,
    M_INT     = 10'b0000000100,
    M_FRAC    = 10'b0000001000,
    M_EXPMARK = 10'b0000010000,
    M_EXPDIG  = 10'b0000100000,
    M_IDENT   = 10'b0001000000,
    M_STR     = 10'b0010000000,
    M_STRQ    = 10'b0100000000,
    M_SKIP    = 10'b1000000000
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
    logic [63:0] ival;
    logic        bval;
    err_t        err;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;    // number of records, 0..3
    rec_t       r0;
    rec_t       r1;
    rec_t       r2;
  } recs_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- sv/fet_lexer.sv -----
// ============================================================================
// fet_lexer: lexer state and per-byte token logic
// Holds the registered lexer state and forms up to three records per byte.
// ============================================================================
module fet_lexer #(
  parameter int unsigned KEYWORD_CHARS = 5,
  parameter int unsigned POS_W         = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     c,
  input  logic           last,
  output fet_pkg::recs_t recs
);
  import fet_pkg::*;

  localparam int unsigned KW_W = 8 * KEYWORD_CHARS;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [15:0]      line_r, line_nxt, tline_r, tline_nxt;
  logic [63:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt, ovf_r, ovf_nxt;
  logic [KW_W-1:0]  kw_r, kw_nxt;
  logic [3:0]       kwl_r, kwl_nxt;

  // working copies during one byte
  mode_t            m;
  logic             taken, fin_err;
  logic [POS_W-1:0] endp;
  logic [1:0]       n;
  rec_t             o [3];
  rec_t             r;
  logic [63:0]      d64, lim, ival;
  logic [67:0]      acc;

  // keyword match on the window
  function automatic logic kw_is(input logic [KW_W-1:0] w, input logic [3:0] l,
                                 input logic [39:0] s, input logic [3:0] sl);
    return l == sl && w == KW_W'(s);
  endfunction

  function automatic rec_t mk(input kind_t k, input logic [15:0] ln,
                              input logic [POS_W-1:0] st, input logic [POS_W-1:0] ln2,
                              input logic [63:0] iv, input logic bv, input err_t e);
    rec_t t;
    t.kind = k; t.line = ln; t.start = 16'(st); t.len = 16'(ln2);
    t.ival = iv; t.bval = bv; t.err = e;
    return t;
  endfunction

  always_comb begin
    mode_nxt = mode_r; pos_nxt = pos_r; tstart_nxt = tstart_r;
    line_nxt = line_r; tline_nxt = tline_r; mag_nxt = mag_r;
    neg_nxt = neg_r; ovf_nxt = ovf_r; kw_nxt = kw_r; kwl_nxt = kwl_r;
    m = mode_r; taken = 1'b0; fin_err = 1'b0; n = 2'd0;
    o[0] = '0; o[1] = '0; o[2] = '0; r = '0;
    endp = pos_r; ival = '0;
    d64 = 64'(c[3:0]);
    // magnitude*10 + d, tested against the signed limit in 68 bits
    lim = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    acc = {1'b0, mag_r, 3'b0} + {3'b0, mag_r, 1'b0} + {4'b0, d64};

    // continuation of the open token
    unique case (mode_r)
      M_MINUS: if (is_digit(c)) begin
        m = M_INT; neg_nxt = 1'b1; ovf_nxt = 1'b0; taken = 1'b1;
        mag_nxt = d64;
      end
      M_INT: begin
        if (is_digit(c)) begin
          taken = 1'b1;
          if (ovf_r || acc > {4'b0, lim}) ovf_nxt = 1'b1;
          else mag_nxt = acc[63:0];
        end else if (c == 8'h2e) begin
          m = M_FRAC; taken = 1'b1;
        end else if (c == 8'h65 || c == 8'h45) begin
          m = M_EXPMARK; taken = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) taken = 1'b1;
        else if (c == 8'h65 || c == 8'h45) begin
          m = M_EXPMARK; taken = 1'b1;
        end
      end
      M_EXPMARK: if (c == 8'h2b || c == 8'h2d || is_digit(c)) begin
        m = M_EXPDIG; taken = 1'b1;
      end
      M_EXPDIG: if (is_digit(c)) taken = 1'b1;
      M_IDENT: if (is_alpha(c) || is_digit(c) || c == 8'h5f || c == 8'h2e || c == 8'h2f) begin
        if (kwl_r <= 4'(KEYWORD_CHARS)) begin
          kw_nxt = {kw_r[KW_W-9:0], to_lower(c)};
          kwl_nxt = kwl_r + 4'd1;
        end
        taken = 1'b1;
      end
      M_STR: begin
        if (c == 8'h27) m = M_STRQ;
        taken = 1'b1;
      end
      M_STRQ: if (c == 8'h27) begin
        m = M_STR; taken = 1'b1;
      end
      M_SKIP: taken = 1'b1;
      M_IDLE: ;
      default: ;
    endcase

    // close the token before this byte, then start from idle
    if (!taken) begin
      ival = neg_r ? 64'd0 - mag_r : mag_r;
      unique case (m)
        M_MINUS: begin
          o[n] = mk(K_ERROR, tline_r, tstart_r, POS_ONE, '0, 1'b0, E_UNEXP);
          n = n + 2'd1; m = M_SKIP; fin_err = 1'b1;
        end
        M_INT: begin
          if (ovf_r) begin
            o[n] = mk(K_ERROR, tline_r, tstart_r, pos_r - tstart_r, '0, 1'b0, E_OVFL);
            m = M_SKIP; fin_err = 1'b1;
          end else begin
            o[n] = mk(K_INT, tline_r, tstart_r, pos_r - tstart_r, ival, 1'b0, E_NONE);
            m = M_IDLE;
          end
          n = n + 2'd1;
        end
        M_FRAC, M_EXPMARK, M_EXPDIG: begin
          o[n] = mk(K_FLOAT, tline_r, tstart_r, pos_r - tstart_r, '0, 1'b0, E_NONE);
          n = n + 2'd1; m = M_IDLE;
        end
        M_IDENT: begin
          r = mk(K_IDENT, tline_r, tstart_r, pos_r - tstart_r, '0, 1'b0, E_NONE);
          if      (kw_is(kw_r, kwl_r, 40'h6571, 4'd2))       r.kind = K_EQ;
          else if (kw_is(kw_r, kwl_r, 40'h6e65, 4'd2))       r.kind = K_NE;
          else if (kw_is(kw_r, kwl_r, 40'h6774, 4'd2))       r.kind = K_GT;
          else if (kw_is(kw_r, kwl_r, 40'h6765, 4'd2))       r.kind = K_GE;
          else if (kw_is(kw_r, kwl_r, 40'h6c74, 4'd2))       r.kind = K_LT;
          else if (kw_is(kw_r, kwl_r, 40'h6c65, 4'd2))       r.kind = K_LE;
          else if (kw_is(kw_r, kwl_r, 40'h616e64, 4'd3))     r.kind = K_AND;
          else if (kw_is(kw_r, kwl_r, 40'h6f72, 4'd2))       r.kind = K_OR;
          else if (kw_is(kw_r, kwl_r, 40'h6e6f74, 4'd3))     r.kind = K_NOT;
          else if (kw_is(kw_r, kwl_r, 40'h74727565, 4'd4)) begin
            r.kind = K_BOOL; r.bval = 1'b1;
          end
          else if (kw_is(kw_r, kwl_r, 40'h66616c7365, 4'd5)) r.kind = K_BOOL;
          else if (kw_is(kw_r, kwl_r, 40'h6e756c6c, 4'd4))   r.kind = K_NULL;
          o[n] = r; n = n + 2'd1; m = M_IDLE;
        end
        M_STRQ: begin
          o[n] = mk(K_STRING, tline_r, tstart_r, pos_r - tstart_r, '0, 1'b0, E_NONE);
          n = n + 2'd1; m = M_IDLE;
        end
        M_STR: begin
          o[n] = mk(K_ERROR, tline_r, tstart_r, pos_r - tstart_r, '0, 1'b0, E_UNTERM);
          n = n + 2'd1; m = M_SKIP; fin_err = 1'b1;
        end
        M_SKIP: fin_err = 1'b1;
        M_IDLE: ;
        default: ;
      endcase

      // idle: start a token or emit a single-character one
      if (!fin_err) begin
        if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
        end else if (c == 8'h0a) begin
          if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        end else if (c == 8'h27) begin
          m = M_STR; tstart_nxt = pos_r; tline_nxt = line_r;
        end else if (is_digit(c)) begin
          m = M_INT; tstart_nxt = pos_r; tline_nxt = line_r;
          neg_nxt = 1'b0; ovf_nxt = 1'b0; mag_nxt = d64;
        end else if (c == 8'h2d) begin
          m = M_MINUS; tstart_nxt = pos_r; tline_nxt = line_r;
        end else if (is_alpha(c) || c == 8'h5f) begin
          m = M_IDENT; tstart_nxt = pos_r; tline_nxt = line_r;
          kw_nxt = KW_W'(to_lower(c)); kwl_nxt = 4'd1;
        end else begin
          r = mk(K_ERROR, line_r, pos_r, POS_ONE, '0, 1'b0, E_UNEXP);
          unique case (c)
            8'h28: r = mk(K_LPAREN, line_r, pos_r, POS_ONE, '0, 1'b0, E_NONE);
            8'h29: r = mk(K_RPAREN, line_r, pos_r, POS_ONE, '0, 1'b0, E_NONE);
            8'h2c: r = mk(K_COMMA,  line_r, pos_r, POS_ONE, '0, 1'b0, E_NONE);
            8'h3a: r = mk(K_COLON,  line_r, pos_r, POS_ONE, '0, 1'b0, E_NONE);
            default: m = M_SKIP;
          endcase
          o[n] = r; n = n + 2'd1;
        end
      end
    end

    // end of text: close what is open, then the end record
    if (last) begin
      endp = pos_r + POS_ONE;
      unique case (m)
        M_MINUS: begin
          o[n] = mk(K_ERROR, tline_nxt, tstart_nxt, POS_ONE, '0, 1'b0, E_UNEXP);
          n = n + 2'd1; m = M_SKIP;
        end
        M_INT: begin
          if (ovf_nxt) begin
            o[n] = mk(K_ERROR, tline_nxt, tstart_nxt, endp - tstart_nxt, '0, 1'b0, E_OVFL);
            m = M_SKIP;
          end else
            o[n] = mk(K_INT, tline_nxt, tstart_nxt, endp - tstart_nxt,
                      neg_nxt ? 64'd0 - mag_nxt : mag_nxt, 1'b0, E_NONE);
          n = n + 2'd1;
        end
        M_FRAC, M_EXPMARK, M_EXPDIG: begin
          o[n] = mk(K_FLOAT, tline_nxt, tstart_nxt, endp - tstart_nxt, '0, 1'b0, E_NONE);
          n = n + 2'd1;
        end
        M_IDENT: begin
          r = mk(K_IDENT, tline_nxt, tstart_nxt, endp - tstart_nxt, '0, 1'b0, E_NONE);
          if      (kw_is(kw_nxt, kwl_nxt, 40'h6571, 4'd2))       r.kind = K_EQ;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6e65, 4'd2))       r.kind = K_NE;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6774, 4'd2))       r.kind = K_GT;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6765, 4'd2))       r.kind = K_GE;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6c74, 4'd2))       r.kind = K_LT;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6c65, 4'd2))       r.kind = K_LE;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h616e64, 4'd3))     r.kind = K_AND;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6f72, 4'd2))       r.kind = K_OR;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6e6f74, 4'd3))     r.kind = K_NOT;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h74727565, 4'd4)) begin
            r.kind = K_BOOL; r.bval = 1'b1;
          end
          else if (kw_is(kw_nxt, kwl_nxt, 40'h66616c7365, 4'd5)) r.kind = K_BOOL;
          else if (kw_is(kw_nxt, kwl_nxt, 40'h6e756c6c, 4'd4))   r.kind = K_NULL;
          o[n] = r; n = n + 2'd1;
        end
        M_STRQ: begin
          o[n] = mk(K_STRING, tline_nxt, tstart_nxt, endp - tstart_nxt, '0, 1'b0, E_NONE);
          n = n + 2'd1;
        end
        M_STR: begin
          o[n] = mk(K_ERROR, tline_nxt, tstart_nxt, endp - tstart_nxt, '0, 1'b0, E_UNTERM);
          n = n + 2'd1; m = M_SKIP;
        end
        M_SKIP: ;
        M_IDLE: ;
        default: ;
      endcase
      if (m != M_SKIP) begin
        o[n] = mk(K_END, line_nxt, endp, '0, '0, 1'b0, E_NONE);
        n = n + 2'd1;
      end
      // back to reset values
      mode_nxt = M_IDLE; pos_nxt = '0; tstart_nxt = '0; line_nxt = 16'd1;
      tline_nxt = 16'd1; mag_nxt = '0; neg_nxt = 1'b0; ovf_nxt = 1'b0;
      kw_nxt = '0; kwl_nxt = '0;
    end else begin
      mode_nxt = m;
      pos_nxt = pos_r + POS_ONE;
    end

    recs.cnt = n; recs.r0 = o[0]; recs.r1 = o[1]; recs.r2 = o[2];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; tstart_r <= '0; line_r <= 16'd1;
      tline_r <= 16'd1; mag_r <= '0; neg_r <= 1'b0; ovf_r <= 1'b0;
      kw_r <= '0; kwl_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; tstart_r <= tstart_nxt;
      line_r <= line_nxt; tline_r <= tline_nxt; mag_r <= mag_nxt;
      neg_r <= neg_nxt; ovf_r <= ovf_nxt; kw_r <= kw_nxt; kwl_r <= kwl_nxt;
    end
  end

  // line counter never reaches zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n) line_r != 16'd0)
    else $error("line count zero");
  // last byte returns the lexer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> mode_r == M_IDLE && pos_r == '0)
    else $error("not idle after last byte");
  // skip mode only left on the last byte
  a_skip_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_SKIP && !(step && last) |=> mode_r == M_SKIP)
    else $error("skip mode left early");

endmodule

// ----- sv/fet_outq.sv -----
// ============================================================================
// fet_outq: record holding buffer and output serializer
// Stores up to three records of one byte and sends them one per word.
// ============================================================================
module fet_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  fet_pkg::recs_t recs_in,
  output logic           free,
  output logic           o_valid,
  input  logic           o_ready,
  output fet_pkg::rec_t  o_rec,
  output logic           o_last
);
  import fet_pkg::*;

  rec_t       buf_r [3];
  logic [1:0] cnt_r, idx_r;
  logic       pop;

  assign o_valid = cnt_r != 2'd0;
  assign pop     = o_valid && o_ready;
  assign o_last  = idx_r + 2'd1 == cnt_r;
  assign free    = !o_valid || (pop && o_last);

  always_comb begin
    unique case (idx_r)
      2'd0:    o_rec = buf_r[0];
      2'd1:    o_rec = buf_r[1];
      default: o_rec = buf_r[2];
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r[0] <= recs_in.r0; buf_r[1] <= recs_in.r1; buf_r[2] <= recs_in.r2;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; idx_r <= '0;
    end else if (load) begin
      cnt_r <= recs_in.cnt; idx_r <= '0;
    end else if (pop) begin
      if (o_last) begin
        cnt_r <= '0; idx_r <= '0;
      end else idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> idx_r < cnt_r) else $error("index past count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> $stable(idx_r) && $stable(cnt_r)) else $error("lost word");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free) else $error("load over pending words");

endmodule

// ----- sv/filter_expression_tokenizer.sv -----
// Output: the records of an accepted byte are registered in fet_outq before they show on out_tdata.
// Throughput: one byte per cycle when each byte gives at most one record and out_tready
// stays high; a byte with several records holds the input until the output buffer drains.
// Reset: synchronous, active low; lexer at idle, offset 0, line 1.
// ============================================================================
// filter_expression_tokenizer: streaming tokenizer for filter text
// Lexer state in fet_lexer, record buffer and serializer in fet_outq.
// ============================================================================
module filter_expression_tokenizer #(
  parameter int unsigned KEYWORD_CHARS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_req
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // kind, line, start_res, span_length, ival,
                                   // bool_value, error
  output logic         out_tlast   // last_of_run
);
  import fet_pkg::*;

  recs_t recs;
  rec_t  rec;
  logic  free, step;

  assign in_tready = free;
  assign step      = in_tvalid && in_tready;

  fet_lexer #(.KEYWORD_CHARS(KEYWORD_CHARS), .POS_W(16)) u_lex (
    .clk(clk), .rst_n(rst_n), .step(step), .c(in_tdata), .last(in_tlast), .recs(recs)
  );

  fet_outq u_q (
    .clk(clk), .rst_n(rst_n), .load(step), .recs_in(recs), .free(free),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_rec(rec), .o_last(out_tlast)
  );

  assign out_tdata = {rec.err, rec.bval, rec.ival, rec.len, rec.start, rec.line,
                      rec.kind};

endmodule
